### src/williams_percent_r_dual_assert.svh
// Assertion macros for the dual percent R block.
// Expect clk and rst_n in the scope of every use.
`ifndef WILLIAMS_PERCENT_R_DUAL_ASSERT_SVH
`define WILLIAMS_PERCENT_R_DUAL_ASSERT_SVH

// Check cons in the same cycle as ante.
`define WPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define WPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/wpr_pkg.sv
// Shared widths, constants and types of the dual percent R block.
// No dependencies.
`default_nettype none

package wpr_pkg;

  localparam int PRICE_W   = 32;
  localparam int WR_W      = 16;
  localparam int WIN_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int SCALE_W   = 15;
  localparam int NUM_W     = PRICE_W + SCALE_W;
  localparam int QUO_W     = 15;
  localparam int LINES     = 2;

  localparam logic [SCALE_W-1:0]   WR_SCALE = 15'd25600;
  localparam logic signed [WR_W-1:0] WR_FULL = 16'sd25600;
  localparam logic signed [WR_W-1:0] WR_NONE = -16'sd12800;

  localparam logic [WIN_W-1:0] WIN_ONE_RST = 7'd14;
  localparam logic [WIN_W-1:0] WIN_TWO_RST = 7'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TWO = 2'd1;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [PRICE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

### src/wpr_ifs.sv
// Channel interfaces: bar requests, result requests and register writes.
// Depends on wpr_pkg.
`default_nettype none

interface wpr_in_if import wpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               start_series;
  logic [PRICE_W-1:0] high_price;
  logic [PRICE_W-1:0] low_price;
  logic [PRICE_W-1:0] close_price;

  modport source(output valid, start_series, high_price, low_price, close_price,
                 input ready);
  modport sink(input valid, start_series, high_price, low_price, close_price,
               output ready);
endinterface

interface wpr_out_if import wpr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [WR_W-1:0] wr_one;
  logic                   wr_one_valid;
  logic signed [WR_W-1:0] wr_two;
  logic                   wr_two_valid;

  modport source(output valid, wr_one, wr_one_valid, wr_two, wr_two_valid,
                 input ready);
  modport sink(input valid, wr_one, wr_one_valid, wr_two, wr_two_valid,
               output ready);
endinterface

interface wpr_cfg_if import wpr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WIN_W-1:0]     data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/wpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wpr_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/wpr_div.sv
// Restoring divider, one quotient bit per cycle, quotient below 2**QUO_W.
// Depends on wpr_pkg.
`default_nettype none

module wpr_div import wpr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output      div_rsp_t rsp
);

  localparam int CNT_W = $clog2(QUO_W);

  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             ge;

  assign ge = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        quo_r <= {quo_r[QUO_W-2:0], ge};
        dsh_r <= dsh_r >> 1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end else if (req.start) begin
        rem_r  <= req.num;
        dsh_r  <= NUM_W'({req.den, {(QUO_W-1){1'b0}}});
        cnt_r  <= CNT_W'(QUO_W - 1);
        busy_r <= 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

`default_nettype wire

### src/williams_percent_r_dual.sv
// Dual percent R over price bars; one bar request in, one result request out.
// Per bar: a history scan over N entries, N the longer clamped window (one RAM
// read a cycle), a drain, then per line an evaluation and, if it divides, multiply,
// start and divider wait, then output. One bar at a time; a finished result may wait.
// Synchronous active-low reset: history empty, windows 14 and 6, no held values.
// Depends on wpr_pkg, wpr_ifs, wpr_ram, wpr_div.
`default_nettype none
`include "williams_percent_r_dual_assert.svh"

module williams_percent_r_dual import wpr_pkg::*; #(
  parameter int WINDOW_MAX = 64
) (
  input wire logic  clk,
  input wire logic  rst_n,
  wpr_cfg_if.sink   cfg_bus,
  wpr_in_if.sink    in_bus,
  wpr_out_if.source out_bus
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_MAX - 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(WINDOW_MAX);
  localparam int SW = $clog2(LINES);
  localparam logic [SW-1:0] LINE_LAST = SW'(LINES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_EVAL, S_MUL, S_GO, S_DIV, S_OUT
  } state_t;

  function automatic logic [CW-1:0] clamp_win(input logic [WIN_W-1:0] w);
    logic [CW-1:0] n;
    if (w == '0) begin
      n = CW'(1);
    end else if (int'(w) > WINDOW_MAX) begin
      n = CNT_MAX;
    end else begin
      n = CW'(w);
    end
    return n;
  endfunction

  state_t state_r;

  logic [WIN_W-1:0] win_one_r;
  logic [WIN_W-1:0] win_two_r;

  logic [AW-1:0]      wp_r;
  logic [CW-1:0]      bars_r;
  logic [AW-1:0]      ra_r;
  logic [AW-1:0]      cnt_r;
  logic [AW-1:0]      rk_r;
  logic               rv_r;
  logic [SW-1:0]      sel_r;
  logic [PRICE_W-1:0] close_r;

  logic [PRICE_W-1:0]     max_r  [LINES];
  logic [PRICE_W-1:0]     min_r  [LINES];
  logic signed [WR_W-1:0] last_r [LINES];
  logic                   have_r [LINES];
  logic signed [WR_W-1:0] res_r  [LINES];
  logic                   ok_r   [LINES];

  logic [PRICE_W-1:0] diff_r;
  logic [PRICE_W-1:0] den_r;
  logic [NUM_W-1:0]   prod_r;

  logic                   out_valid_r;
  logic signed [WR_W-1:0] out_one_r;
  logic                   out_one_ok_r;
  logic signed [WR_W-1:0] out_two_r;
  logic                   out_two_ok_r;

  logic [CW-1:0]          n_line [LINES];
  logic [CW-1:0]          n_max;
  logic [AW-1:0]          wp_base;
  logic [CW-1:0]          bars_base;
  logic                   accept;
  logic [2*PRICE_W-1:0]   rd_data;
  logic [PRICE_W-1:0]     rd_high;
  logic [PRICE_W-1:0]     rd_low;
  logic [PRICE_W-1:0]     cur_max;
  logic [PRICE_W-1:0]     cur_min;
  logic                   cur_ok;
  logic signed [WR_W-1:0] eval_res_nxt;
  logic                   eval_div_nxt;
  logic [NUM_W-1:0]       prod_nxt;
  logic signed [WR_W-1:0] quot_val;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign n_line[0] = clamp_win(win_one_r);
  assign n_line[1] = clamp_win(win_two_r);
  assign n_max     = (n_line[0] > n_line[1]) ? n_line[0] : n_line[1];

  assign accept    = (state_r == S_IDLE) && in_bus.valid;
  assign wp_base   = in_bus.start_series ? '0 : wp_r;
  assign bars_base = in_bus.start_series ? '0 : bars_r;

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;

  wpr_ram #(
    .DATA_W (2 * PRICE_W),
    .DEPTH  (WINDOW_MAX)
  ) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (wp_base),
    .wdata ({in_bus.high_price, in_bus.low_price}),
    .re    (state_r == S_SCAN),
    .raddr (ra_r),
    .rdata (rd_data)
  );

  assign rd_high = rd_data[2*PRICE_W-1:PRICE_W];
  assign rd_low  = rd_data[PRICE_W-1:0];

  assign cur_max = max_r[sel_r];
  assign cur_min = min_r[sel_r];
  assign cur_ok  = (bars_r >= n_line[sel_r]);

  always_comb begin
    eval_res_nxt = '0;
    eval_div_nxt = 1'b0;
    priority if (!cur_ok) begin
      eval_res_nxt = '0;
    end else if (cur_max <= cur_min) begin
      eval_res_nxt = have_r[sel_r] ? last_r[sel_r] : WR_NONE;
    end else if (close_r >= cur_max) begin
      eval_res_nxt = '0;
    end else if (close_r <= cur_min) begin
      eval_res_nxt = WR_FULL;
    end else begin
      eval_div_nxt = 1'b1;
    end
  end

  assign prod_nxt = NUM_W'(diff_r) * NUM_W'(WR_SCALE);

  assign div_req.start = (state_r == S_GO);
  assign div_req.num   = prod_r;
  assign div_req.den   = den_r;

  wpr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign quot_val = $signed(WR_W'(div_rsp.quot));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_one_r <= WIN_ONE_RST;
      win_two_r <= WIN_TWO_RST;
    end else if (cfg_bus.valid) begin
      if (cfg_bus.index == CFG_WINDOW_ONE) begin
        win_one_r <= cfg_bus.data;
      end else if (cfg_bus.index == CFG_WINDOW_TWO) begin
        win_two_r <= cfg_bus.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      bars_r      <= '0;
      rv_r        <= 1'b0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LINES; i++) begin
        have_r[i] <= 1'b0;
        last_r[i] <= '0;
      end
    end else begin
      rv_r <= (state_r == S_SCAN);
      if ((state_r == S_OUT) && (!out_valid_r || out_bus.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end

      if (rv_r) begin
        for (int i = 0; i < LINES; i++) begin
          if (rk_r == '0) begin
            max_r[i] <= rd_high;
            min_r[i] <= rd_low;
          end else if (CW'(rk_r) < n_line[i]) begin
            if (rd_high > max_r[i]) begin
              max_r[i] <= rd_high;
            end
            if (rd_low < min_r[i]) begin
              min_r[i] <= rd_low;
            end
          end
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_bus.valid) begin
            if (in_bus.start_series) begin
              for (int i = 0; i < LINES; i++) begin
                have_r[i] <= 1'b0;
                last_r[i] <= '0;
              end
            end
            wp_r    <= (wp_base == PTR_LAST) ? '0 : wp_base + 1'b1;
            bars_r  <= (bars_base == CNT_MAX) ? CNT_MAX : bars_base + 1'b1;
            ra_r    <= wp_base;
            cnt_r   <= '0;
            sel_r   <= '0;
            close_r <= in_bus.close_price;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          rk_r  <= cnt_r;
          ra_r  <= (ra_r == '0) ? PTR_LAST : ra_r - 1'b1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == AW'(n_max - 1'b1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          res_r[sel_r] <= eval_res_nxt;
          ok_r[sel_r]  <= cur_ok;
          if (eval_div_nxt) begin
            diff_r  <= cur_max - close_r;
            den_r   <= cur_max - cur_min;
            state_r <= S_MUL;
          end else begin
            if (cur_ok) begin
              last_r[sel_r] <= eval_res_nxt;
              have_r[sel_r] <= 1'b1;
            end
            if (sel_r == LINE_LAST) begin
              state_r <= S_OUT;
            end else begin
              sel_r <= sel_r + 1'b1;
            end
          end
        end
        S_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= S_GO;
        end
        S_GO: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res_r[sel_r]  <= quot_val;
            last_r[sel_r] <= quot_val;
            have_r[sel_r] <= 1'b1;
            if (sel_r == LINE_LAST) begin
              state_r <= S_OUT;
            end else begin
              sel_r   <= sel_r + 1'b1;
              state_r <= S_EVAL;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_bus.ready) begin
            out_one_r    <= res_r[0];
            out_one_ok_r <= ok_r[0];
            out_two_r    <= res_r[1];
            out_two_ok_r <= ok_r[1];
            state_r      <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.wr_one       = out_one_r;
  assign out_bus.wr_one_valid = out_one_ok_r;
  assign out_bus.wr_two       = out_two_r;
  assign out_bus.wr_two_valid = out_two_ok_r;

  `WPR_ASSERT_NEXT(a_busy_after_accept, in_bus.valid && in_bus.ready, !in_bus.ready, "bar accepted twice in a row")
  `WPR_ASSERT_NOW(a_div_done_in_wait, div_rsp.done, state_r == S_DIV, "quotient arrived outside the wait state")
  `WPR_ASSERT_NOW(a_bars_bounded, 1'b1, bars_r <= CNT_MAX, "bar count above window depth")
  `WPR_ASSERT_NOW(a_short_window_zero, out_bus.valid && (!out_bus.wr_one_valid || !out_bus.wr_two_valid), (out_bus.wr_one_valid || out_bus.wr_one == '0) && (out_bus.wr_two_valid || out_bus.wr_two == '0), "line without a full window is not zero")
  `WPR_ASSERT_NOW(a_one_in_range, out_bus.valid && out_bus.wr_one_valid, (out_bus.wr_one >= 16'sd0 && out_bus.wr_one <= WR_FULL) || out_bus.wr_one == WR_NONE, "first line out of range")

endmodule

`default_nettype wire
